FILE: src/vsl_pkg.sv
// Package for the velocity slew limiter: fixed-point constants, sequencer states,
// register indexes and the request type of the shared sqrt/divide unit.
// No dependencies.
package vsl_pkg;

  localparam int FRAC_BITS = 16;
  localparam logic [31:0] MOVE_THRESH = 32'((64'd5 << FRAC_BITS) / 64'd100);
  localparam logic [63:0] SAT_MAX = 64'd2147483647;
  localparam logic [29:0] LEN2_ONE = 30'd268435456;

  typedef enum logic [4:0] {
    ST_IDLE, ST_FSQ, ST_SSQ, ST_LEN, ST_LWAIT, ST_DF, ST_DS,
    ST_TS, ST_TF, ST_TSF, ST_TT, ST_RF, ST_RS, ST_RT, ST_APT,
    ST_VSQ, ST_VSQ2, ST_SPD, ST_SWAIT
  } state_e;

  typedef enum logic [2:0] {
    REG_WALK_SPEED, REG_SPRINT_MULT, REG_ACCEL_RATE,
    REG_DECEL_RATE, REG_TURN_SPEED, REG_TURN_ACCEL
  } reg_idx_e;

  typedef enum logic {
    MODE_SQRT, MODE_DIV
  } iter_mode_e;

  typedef struct packed {
    logic       start;
    iter_mode_e mode;
  } iter_req_t;

  // move a Q.16 magnitude to FRAC_BITS fraction bits
  function automatic logic [63:0] to_frac(logic [63:0] mag);
    if (FRAC_BITS >= 16) begin
      return mag << (FRAC_BITS - 16);
    end else begin
      return mag >> (16 - FRAC_BITS);
    end
  endfunction

endpackage

FILE: src/vsl_iter.sv
// Shared iterative unit: 32-step integer square root of a 64-bit value or
// 32-bit by 17-bit restoring division, one result bit per cycle. Uses vsl_pkg.
module vsl_iter (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  vsl_pkg::iter_req_t req_i,
  input  logic [63:0]        x_i,
  input  logic [16:0]        div_i,
  output logic [31:0]        res_o,
  output logic               done_o
);

  logic [63:0] x_q;
  logic [35:0] rem_q;
  logic [31:0] root_q;
  logic [16:0] div_q;
  logic [4:0]  cnt_q;
  logic        busy_q;
  logic        done_q;
  vsl_pkg::iter_mode_e mode_q;

  logic [35:0] rem_s;
  logic [35:0] trial;
  logic        ge;

  always_comb begin
    if (mode_q == vsl_pkg::MODE_SQRT) begin
      rem_s = {rem_q[33:0], x_q[63:62]};
      trial = {2'b00, root_q, 2'b01};
    end else begin
      rem_s = {rem_q[34:0], x_q[63]};
      trial = {19'd0, div_q};
    end
    ge = (rem_s >= trial);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      mode_q <= vsl_pkg::MODE_SQRT;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= 5'd31;
      mode_q <= req_i.mode;
    end else if (busy_q) begin
      cnt_q <= cnt_q - 5'd1;
      if (cnt_q == 5'd0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      x_q    <= x_i;
      div_q  <= div_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      x_q    <= (mode_q == vsl_pkg::MODE_SQRT) ? {x_q[61:0], 2'b00} : {x_q[62:0], 1'b0};
      rem_q  <= ge ? rem_s - trial : rem_s;
      root_q <= {root_q[30:0], ge};
    end
  end

  assign res_o  = root_q;
  assign done_o = done_q;

endmodule

FILE: src/velocity_slew_limiter_core.sv
// Top level of the velocity slew limiter: config registers, input capture,
// sequencer with one shared multiplier, and the output register.
// Depends on vsl_pkg and vsl_iter.
//
// Usage: items enter on the s_axis channel and each gives one result on m_axis.
// An update item normalizes the forward/strafe vector when needed and then
// slews the velocities; a stop item or a zero time step goes straight to the
// speed calculation. The next item is taken after the result is loaded and
// the sequencer is idle again. The work is the square root of the speed, plus
// one square root and two divisions for normalizing, all on the shared
// iterative unit, and one product per cycle from the shared multiplier.
// s_axis_tready is high only while the sequencer is idle. The result is held in
// an output register; if the receiver stalls, the next item is accepted and
// worked, and it waits at its end until the held result is taken.
// Config writes on the cfg channel are always taken, and must only be issued
// while the block is idle. Reset clears the velocities to zero and loads the
// default register values; no result is pending after reset.
module velocity_slew_limiter_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // delta_time[19:0], forward_cmd[35:20], strafe_cmd[51:36], turn_cmd[67:52], zero pad
  input  logic [71:0]  s_axis_tdata,
  // kind[0], sprint[1]
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // forward_vel[31:0], strafe_vel[63:32], turn_vel[95:64], speed[127:96]
  output logic [127:0] m_axis_tdata,
  // moving[0]
  output logic [0:0]   m_axis_tuser,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [2:0]   cfg_index_i,
  input  logic [23:0]  cfg_data_i
);

  logic [23:0] walk_q, accel_q, decel_q, tspeed_q, taccel_q;
  logic [15:0] smult_q;

  vsl_pkg::state_e state_q, state_d;

  logic [19:0] dt_q;
  logic        sprint_q;
  logic [14:0] fm_q, sm_q, tm_q;
  logic        fneg_q, sneg_q, tneg_q;
  logic [29:0] len2_q;
  logic [16:0] len_q;
  logic [27:0] ts_q;
  logic [30:0] tf_q, tsf_q, tt_q;
  logic [63:0] sum_q;
  logic [63:0] prod_q;
  logic [31:0] fv_q, sv_q, tv_q;
  logic        mvalid_q;
  logic [127:0] mdata_q;
  logic         moving_q;

  logic [31:0] mul_a, mul_b;
  vsl_pkg::iter_req_t ireq;
  logic [63:0] ix;
  logic [16:0] idiv;
  logic [31:0] ires;
  logic        idone;
  logic        load_out;

  logic [29:0] len2;
  logic [63:0] step;
  logic [31:0] afv, asv;

  vsl_iter u_iter (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (ireq),
    .x_i    (ix),
    .div_i  (idiv),
    .res_o  (ires),
    .done_o (idone)
  );

  function automatic logic [15:0] clamp_cmd(logic signed [15:0] c);
    logic [15:0] r;
    if (c > $signed(16'd16384)) begin
      r = 16'd16384;
    end else if (c < -$signed(16'd16384)) begin
      r = 16'hC000;
    end else begin
      r = c;
    end
    return r;
  endfunction

  function automatic logic [14:0] mag15(logic [15:0] c);
    logic [15:0] m;
    m = c[15] ? 16'(-c) : c;
    return m[14:0];
  endfunction

  function automatic logic [30:0] sat_target(logic [63:0] p);
    logic [63:0] t;
    t = vsl_pkg::to_frac(p >> 14);
    return (t > vsl_pkg::SAT_MAX) ? 31'h7FFFFFFF : t[30:0];
  endfunction

  function automatic logic [31:0] abs32(logic [31:0] v);
    return v[31] ? 32'(-v) : v;
  endfunction

  function automatic logic [31:0] slew(logic [31:0] v, logic [30:0] tmag, logic tneg,
                                       logic [63:0] st);
    logic signed [32:0] tgt;
    logic signed [32:0] diff;
    logic [32:0]        ad;
    logic [31:0]        r;
    tgt  = tneg ? -$signed({2'b00, tmag}) : $signed({2'b00, tmag});
    diff = tgt - $signed({v[31], v});
    ad   = diff[32] ? 33'(-diff) : 33'(diff);
    if ({31'd0, ad} <= st) begin
      r = tgt[31:0];
    end else if (diff[32]) begin
      r = v - st[31:0];
    end else begin
      r = v + st[31:0];
    end
    return r;
  endfunction

  assign len2 = len2_q + prod_q[29:0];
  assign step = vsl_pkg::to_frac(prod_q >> 16);
  assign afv  = abs32(fv_q);
  assign asv  = abs32(sv_q);
  assign load_out = (state_q == vsl_pkg::ST_SWAIT) && idone && (!mvalid_q || m_axis_tready);

  always_comb begin
    state_d    = state_q;
    mul_a      = '0;
    mul_b      = '0;
    ireq.start = 1'b0;
    ireq.mode  = vsl_pkg::MODE_DIV;
    ix         = '0;
    idiv       = len_q;
    case (state_q)
      vsl_pkg::ST_IDLE: begin
        if (s_axis_tvalid) begin
          if (s_axis_tuser[0] || s_axis_tdata[19:0] == 20'd0) begin
            state_d = vsl_pkg::ST_VSQ;
          end else begin
            state_d = vsl_pkg::ST_FSQ;
          end
        end
      end
      vsl_pkg::ST_FSQ: begin
        mul_a   = {17'd0, fm_q};
        mul_b   = {17'd0, fm_q};
        state_d = vsl_pkg::ST_SSQ;
      end
      vsl_pkg::ST_SSQ: begin
        mul_a   = {17'd0, sm_q};
        mul_b   = {17'd0, sm_q};
        state_d = vsl_pkg::ST_LEN;
      end
      vsl_pkg::ST_LEN: begin
        if (len2 > vsl_pkg::LEN2_ONE) begin
          ireq.start = 1'b1;
          ireq.mode  = vsl_pkg::MODE_SQRT;
          ix         = {30'd0, len2, 4'd0};
          state_d    = vsl_pkg::ST_LWAIT;
        end else begin
          state_d = vsl_pkg::ST_TS;
        end
      end
      vsl_pkg::ST_LWAIT: begin
        idiv = ires[16:0];
        ix   = {1'b0, fm_q, 16'd0, 32'd0};
        if (idone) begin
          ireq.start = 1'b1;
          state_d    = vsl_pkg::ST_DF;
        end
      end
      vsl_pkg::ST_DF: begin
        ix = {1'b0, sm_q, 16'd0, 32'd0};
        if (idone) begin
          ireq.start = 1'b1;
          state_d    = vsl_pkg::ST_DS;
        end
      end
      vsl_pkg::ST_DS: begin
        if (idone) begin
          state_d = vsl_pkg::ST_TS;
        end
      end
      vsl_pkg::ST_TS: begin
        mul_a   = {8'd0, walk_q};
        mul_b   = sprint_q ? {16'd0, smult_q} : 32'd4096;
        state_d = vsl_pkg::ST_TF;
      end
      vsl_pkg::ST_TF: begin
        mul_a   = {17'd0, fm_q};
        mul_b   = {4'd0, prod_q[39:12]};
        state_d = vsl_pkg::ST_TSF;
      end
      vsl_pkg::ST_TSF: begin
        mul_a   = {17'd0, sm_q};
        mul_b   = {4'd0, ts_q};
        state_d = vsl_pkg::ST_TT;
      end
      vsl_pkg::ST_TT: begin
        mul_a   = {17'd0, tm_q};
        mul_b   = {8'd0, tspeed_q};
        state_d = vsl_pkg::ST_RF;
      end
      vsl_pkg::ST_RF: begin
        mul_a   = ({1'b0, tf_q} < afv) ? {8'd0, decel_q} : {8'd0, accel_q};
        mul_b   = {12'd0, dt_q};
        state_d = vsl_pkg::ST_RS;
      end
      vsl_pkg::ST_RS: begin
        mul_a   = ({1'b0, tsf_q} < asv) ? {8'd0, decel_q} : {8'd0, accel_q};
        mul_b   = {12'd0, dt_q};
        state_d = vsl_pkg::ST_RT;
      end
      vsl_pkg::ST_RT: begin
        mul_a   = {8'd0, taccel_q};
        mul_b   = {12'd0, dt_q};
        state_d = vsl_pkg::ST_APT;
      end
      vsl_pkg::ST_APT: begin
        state_d = vsl_pkg::ST_VSQ;
      end
      vsl_pkg::ST_VSQ: begin
        mul_a   = afv;
        mul_b   = afv;
        state_d = vsl_pkg::ST_VSQ2;
      end
      vsl_pkg::ST_VSQ2: begin
        mul_a   = asv;
        mul_b   = asv;
        state_d = vsl_pkg::ST_SPD;
      end
      vsl_pkg::ST_SPD: begin
        ireq.start = 1'b1;
        ireq.mode  = vsl_pkg::MODE_SQRT;
        ix         = sum_q + prod_q;
        state_d    = vsl_pkg::ST_SWAIT;
      end
      vsl_pkg::ST_SWAIT: begin
        if (load_out) begin
          state_d = vsl_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = vsl_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= vsl_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      walk_q   <= 24'd262144;
      smult_q  <= 16'd6144;
      accel_q  <= 24'd1310720;
      decel_q  <= 24'd1966080;
      tspeed_q <= 24'd196608;
      taccel_q <= 24'd786432;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        vsl_pkg::REG_WALK_SPEED:  walk_q   <= cfg_data_i;
        vsl_pkg::REG_SPRINT_MULT: smult_q  <= cfg_data_i[15:0];
        vsl_pkg::REG_ACCEL_RATE:  accel_q  <= cfg_data_i;
        vsl_pkg::REG_DECEL_RATE:  decel_q  <= cfg_data_i;
        vsl_pkg::REG_TURN_SPEED:  tspeed_q <= cfg_data_i;
        vsl_pkg::REG_TURN_ACCEL:  taccel_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q     <= '0;
      sv_q     <= '0;
      tv_q     <= '0;
      mvalid_q <= 1'b0;
    end else begin
      if (state_q == vsl_pkg::ST_IDLE && s_axis_tvalid && s_axis_tuser[0]) begin
        fv_q <= '0;
        sv_q <= '0;
        tv_q <= '0;
      end
      if (state_q == vsl_pkg::ST_RS) begin
        fv_q <= slew(fv_q, tf_q, fneg_q, step);
      end
      if (state_q == vsl_pkg::ST_RT) begin
        sv_q <= slew(sv_q, tsf_q, sneg_q, step);
      end
      if (state_q == vsl_pkg::ST_APT) begin
        tv_q <= slew(tv_q, tt_q, tneg_q, step);
      end
      if (load_out) begin
        mvalid_q <= 1'b1;
      end else if (m_axis_tready) begin
        mvalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    if (state_q == vsl_pkg::ST_IDLE && s_axis_tvalid) begin
      dt_q     <= s_axis_tdata[19:0];
      sprint_q <= s_axis_tuser[1];
      fm_q     <= mag15(clamp_cmd(s_axis_tdata[35:20]));
      sm_q     <= mag15(clamp_cmd(s_axis_tdata[51:36]));
      tm_q     <= mag15(clamp_cmd(s_axis_tdata[67:52]));
      fneg_q   <= s_axis_tdata[35];
      sneg_q   <= s_axis_tdata[51];
      tneg_q   <= s_axis_tdata[67];
    end
    if (state_q == vsl_pkg::ST_SSQ) begin
      len2_q <= prod_q[29:0];
    end
    if (state_q == vsl_pkg::ST_LWAIT && idone) begin
      len_q <= ires[16:0];
    end
    if (state_q == vsl_pkg::ST_DF && idone) begin
      fm_q <= ires[14:0];
    end
    if (state_q == vsl_pkg::ST_DS && idone) begin
      sm_q <= ires[14:0];
    end
    if (state_q == vsl_pkg::ST_TF) begin
      ts_q <= prod_q[39:12];
    end
    if (state_q == vsl_pkg::ST_TSF) begin
      tf_q <= sat_target(prod_q);
    end
    if (state_q == vsl_pkg::ST_TT) begin
      tsf_q <= sat_target(prod_q);
    end
    if (state_q == vsl_pkg::ST_RF) begin
      tt_q <= sat_target(prod_q);
    end
    if (state_q == vsl_pkg::ST_VSQ2) begin
      sum_q <= prod_q;
    end
    if (load_out) begin
      mdata_q  <= {ires, tv_q, sv_q, fv_q};
      moving_q <= (ires > vsl_pkg::MOVE_THRESH);
    end
  end

  assign s_axis_tready   = (state_q == vsl_pkg::ST_IDLE);
  assign m_axis_tvalid   = mvalid_q;
  assign m_axis_tdata    = mdata_q;
  assign m_axis_tuser[0] = moving_q;
  assign cfg_ready_o     = 1'b1;

endmodule
